// File: design/linear_interp_upsampler_stereo_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the linear interpolation upsampler
// Concurrent checks sampled on clk and held off while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef LINEAR_INTERP_UPSAMPLER_STEREO_MACROS_SVH
`define LINEAR_INTERP_UPSAMPLER_STEREO_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication
`define LIUS_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lius: same-cycle check failed");

// Next-cycle implication
`define LIUS_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lius: next-cycle check failed");

`else

`define LIUS_ASSERT_IMP(name, ante, cons)
`define LIUS_ASSERT_NXT(name, ante, cons)

`endif

`endif

// File: design/lius_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lius_pkg
// Shared widths, job descriptor, sequencer states and the reciprocal table
// for the linear interpolation upsampler.
// ---------------------------------------------------------------------------
package lius_pkg;

  // Field widths
  localparam int SAMPLE_W     = 16;
  localparam int CFG_W        = 5;
  localparam int REPEAT_RESET = 3;

  // Frame budget per utterance
  localparam int FRAME_LIMIT = 524288;
  localparam int FRAMES_W    = 20;

  // Repeat count range and derived widths
  localparam int MAX_REPEAT = 16;
  localparam int REP_W      = $clog2(MAX_REPEAT + 1);
  localparam int CNT_W      = $clog2(MAX_REPEAT);

  // Interpolation numerator: sample times repeat count
  localparam int ACC_W  = SAMPLE_W + REP_W;
  localparam int MAG_W  = ACC_W - 1;
  localparam int DIFF_W = SAMPLE_W + 1;

  // Reciprocal divide: q = (|n| * ceil(2^SHIFT / d)) >> SHIFT, exact for |n| < 2^MAG_W
  localparam int RECIP_SHIFT = 25;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam int PROD_W      = MAG_W + RECIP_W;

  // Job queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // One accepted sample, classified by the front
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] prev;
    logic signed [SAMPLE_W-1:0] curr;
    logic                       interp;  // a previous sample exists
    logic                       eou;     // final sample: hold frames, then clear
  } job_t;

  // Queue head as seen by the back
  typedef struct packed {
    logic valid;
    job_t job;
  } q_head_t;

  // Back sequencer states
  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_INTERP,
    SEQ_HOLD
  } seq_state_t;

  // Clamp the configured count into 1..MAX_REPEAT
  function automatic logic [REP_W-1:0] clamp_repeat(input logic [CFG_W-1:0] r);
    logic [REP_W-1:0] res;
    if (r == '0) begin
      res = REP_W'(1);
    end else if (r > CFG_W'(MAX_REPEAT)) begin
      res = REP_W'(MAX_REPEAT);
    end else begin
      res = REP_W'(r);
    end
    return res;
  endfunction

  // ceil(2^RECIP_SHIFT / d) for d = 1..MAX_REPEAT
  function automatic logic [RECIP_W-1:0] recip(input logic [REP_W-1:0] d);
    logic [RECIP_W-1:0] res;
    unique case (d)
      REP_W'(1):  res = RECIP_W'(33554432);
      REP_W'(2):  res = RECIP_W'(16777216);
      REP_W'(3):  res = RECIP_W'(11184811);
      REP_W'(4):  res = RECIP_W'(8388608);
      REP_W'(5):  res = RECIP_W'(6710887);
      REP_W'(6):  res = RECIP_W'(5592406);
      REP_W'(7):  res = RECIP_W'(4793491);
      REP_W'(8):  res = RECIP_W'(4194304);
      REP_W'(9):  res = RECIP_W'(3728271);
      REP_W'(10): res = RECIP_W'(3355444);
      REP_W'(11): res = RECIP_W'(3050403);
      REP_W'(12): res = RECIP_W'(2796203);
      REP_W'(13): res = RECIP_W'(2581111);
      REP_W'(14): res = RECIP_W'(2396746);
      REP_W'(15): res = RECIP_W'(2236963);
      REP_W'(16): res = RECIP_W'(2097152);
      default:    res = RECIP_W'(33554432);
    endcase
    return res;
  endfunction

endpackage

// File: design/lius_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lius_if
// Valid/ready channel interfaces: mono sample input and stereo frame output.
// ---------------------------------------------------------------------------
interface lius_in_if import lius_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_in;
  logic                       end_of_utterance;

  modport source (output valid, output sample_in, output end_of_utterance, input ready);
  modport sink   (input valid, input sample_in, input end_of_utterance, output ready);
endinterface

interface lius_out_if import lius_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] left_out;
  logic signed [SAMPLE_W-1:0] right_out;
  logic                       last_frame;
  logic                       truncated;

  modport source (output valid, output left_out, output right_out, output last_frame,
                  output truncated, input ready);
  modport sink   (input valid, input left_out, input right_out, input last_frame,
                  input truncated, output ready);
endinterface

// File: design/lius_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lius_front
// Accepts samples, tracks the previous sample and turns each transfer into
// a job descriptor for the queue.
// ---------------------------------------------------------------------------
module lius_front import lius_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  lius_in_if.sink   in_ch,
  input  logic      queue_full,
  output logic      push_valid,
  output job_t      push_job
);

  logic signed [SAMPLE_W-1:0] prev_r, prev_nxt;
  logic                       have_prev_r, have_prev_nxt;
  logic                       accept;

  assign in_ch.ready = !queue_full;
  assign accept      = in_ch.valid && in_ch.ready;

  // Job built from the stored sample and the incoming one
  assign push_valid      = accept;
  assign push_job.prev   = prev_r;
  assign push_job.curr   = in_ch.sample_in;
  assign push_job.interp = have_prev_r;
  assign push_job.eou    = in_ch.end_of_utterance;

  // Previous-sample tracking; end of utterance starts over
  always_comb begin
    prev_nxt      = prev_r;
    have_prev_nxt = have_prev_r;
    if (accept) begin
      if (in_ch.end_of_utterance) begin
        prev_nxt      = '0;
        have_prev_nxt = 1'b0;
      end else begin
        prev_nxt      = in_ch.sample_in;
        have_prev_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r      <= '0;
      have_prev_r <= 1'b0;
    end else begin
      prev_r      <= prev_nxt;
      have_prev_r <= have_prev_nxt;
    end
  end

endmodule

// File: design/lius_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lius_queue
// Short job FIFO between the front and the back.
// ---------------------------------------------------------------------------
module lius_queue import lius_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push_valid,
  input  job_t    push_job,
  output logic    full,
  input  logic    pop,
  output q_head_t head
);

  job_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_push, do_pop;

  assign full       = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign head.valid = (count_r != '0);
  assign head.job   = mem_r[rd_ptr_r];

  assign do_push = push_valid && !full;
  assign do_pop  = pop && head.valid;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage, no reset
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// File: design/lius_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lius_back
// Frame sequencer with capacity tracking, followed by a reciprocal-multiply
// divide pipeline and the output register.
// ---------------------------------------------------------------------------
module lius_back import lius_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [CFG_W-1:0] repeat_count,
  input  q_head_t          head,
  output logic             pop,
  lius_out_if.source       out_ch
);

  // Sequencer state
  seq_state_t                 state_r, state_nxt;
  logic signed [ACC_W-1:0]    acc_r, acc_nxt;
  logic signed [DIFF_W-1:0]   diff_r, diff_nxt;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic                       eou_r, eou_nxt;
  logic [FRAMES_W-1:0]        fe_r, fe_nxt;
  logic                       cap_r, cap_nxt;

  // Issue stage
  logic                       a_valid_r;
  logic                       a_neg_r;
  logic [MAG_W-1:0]           a_mag_r;
  logic [REP_W-1:0]           a_rep_r;
  logic                       a_last_r, a_trunc_r;

  // Product stage
  logic                       b_valid_r;
  logic                       b_neg_r;
  logic [PROD_W-1:0]          b_prod_r;
  logic                       b_last_r, b_trunc_r;

  // Output stage
  logic                       c_valid_r;
  logic signed [SAMPLE_W-1:0] c_data_r;
  logic                       c_last_r, c_trunc_r;

  logic [REP_W-1:0]           rep;
  logic [CNT_W-1:0]           rep_m1;
  logic                       advance;
  logic [FRAMES_W-1:0]        fe_inc;
  logic                       hit;
  logic                       issue, issue_last, issue_trunc, nat_last;
  logic signed [SAMPLE_W-1:0] mul_src;
  logic signed [ACC_W-1:0]    mul_a, mul_b, mul_p;
  logic [MAG_W-1:0]           quot;
  logic signed [MAG_W:0]      quot_s;

  assign rep     = clamp_repeat(repeat_count);
  assign rep_m1  = CNT_W'(rep - REP_W'(1));
  assign advance = !c_valid_r || out_ch.ready;
  assign fe_inc  = fe_r + FRAMES_W'(1);
  assign hit     = (fe_inc >= FRAMES_W'(FRAME_LIMIT));

  // Start numerator: previous (or final) sample times the repeat count
  assign mul_src = head.job.interp ? head.job.prev : head.job.curr;
  assign mul_a   = ACC_W'(mul_src);
  assign mul_b   = ACC_W'($signed({1'b0, rep}));
  assign mul_p   = mul_a * mul_b;

  // Sequencer: one frame per cycle while the pipeline advances
  always_comb begin
    state_nxt   = state_r;
    acc_nxt     = acc_r;
    diff_nxt    = diff_r;
    cnt_nxt     = cnt_r;
    eou_nxt     = eou_r;
    fe_nxt      = fe_r;
    cap_nxt     = cap_r;
    pop         = 1'b0;
    issue       = 1'b0;
    issue_last  = 1'b0;
    issue_trunc = 1'b0;
    nat_last    = 1'b0;
    unique case (state_r)
      SEQ_IDLE: begin
        if (head.valid) begin
          pop = 1'b1;
          if (!cap_r && head.job.interp) begin
            acc_nxt   = mul_p;
            diff_nxt  = DIFF_W'(head.job.curr) - DIFF_W'(head.job.prev);
            cnt_nxt   = '0;
            eou_nxt   = head.job.eou;
            state_nxt = SEQ_INTERP;
          end else if (!cap_r && head.job.eou) begin
            acc_nxt   = mul_p;
            diff_nxt  = '0;
            cnt_nxt   = '0;
            eou_nxt   = 1'b1;
            state_nxt = SEQ_HOLD;
          end else if (head.job.eou) begin
            fe_nxt  = '0;
            cap_nxt = 1'b0;
          end
        end
      end
      SEQ_INTERP: begin
        if (advance) begin
          issue   = 1'b1;
          fe_nxt  = fe_inc;
          acc_nxt = acc_r + ACC_W'(diff_r);
          cnt_nxt = cnt_r + CNT_W'(1);
          if (hit) begin
            // capacity filled mid-ramp: stop the job
            issue_last  = 1'b1;
            issue_trunc = 1'b1;
            state_nxt   = SEQ_IDLE;
            if (eou_r) begin
              fe_nxt  = '0;
              cap_nxt = 1'b0;
            end else begin
              cap_nxt = 1'b1;
            end
          end else if (cnt_r == rep_m1) begin
            // after R steps acc holds curr*R, ready for the hold frames
            if (eou_r) begin
              cnt_nxt   = '0;
              diff_nxt  = '0;
              state_nxt = SEQ_HOLD;
            end else begin
              state_nxt = SEQ_IDLE;
            end
          end
        end
      end
      SEQ_HOLD: begin
        if (advance) begin
          issue       = 1'b1;
          nat_last    = (cnt_r == rep_m1);
          fe_nxt      = fe_inc;
          cnt_nxt     = cnt_r + CNT_W'(1);
          issue_last  = nat_last || hit;
          issue_trunc = hit && !nat_last;
          if (hit || nat_last) begin
            state_nxt = SEQ_IDLE;
            fe_nxt    = '0;
            cap_nxt   = 1'b0;
          end
        end
      end
      default: begin
        state_nxt = SEQ_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SEQ_IDLE;
      fe_r    <= '0;
      cap_r   <= 1'b0;
      eou_r   <= 1'b0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      fe_r    <= fe_nxt;
      cap_r   <= cap_nxt;
      eou_r   <= eou_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r  <= acc_nxt;
    diff_r <= diff_nxt;
  end

  // Pipeline valids: the whole pipe moves when the output slot frees
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
    end else if (advance) begin
      a_valid_r <= issue;
      b_valid_r <= a_valid_r;
      c_valid_r <= b_valid_r;
    end
  end

  // Divide pipeline payload
  assign quot   = b_prod_r[RECIP_SHIFT +: MAG_W];
  assign quot_s = $signed({1'b0, quot});

  always_ff @(posedge clk) begin
    if (advance) begin
      // issue: split numerator into sign and magnitude
      a_neg_r   <= acc_r[ACC_W-1];
      a_mag_r   <= acc_r[ACC_W-1] ? MAG_W'(-acc_r) : MAG_W'(acc_r);
      a_rep_r   <= rep;
      a_last_r  <= issue_last;
      a_trunc_r <= issue_trunc;
      // multiply by the reciprocal
      b_neg_r   <= a_neg_r;
      b_prod_r  <= a_mag_r * recip(a_rep_r);
      b_last_r  <= a_last_r;
      b_trunc_r <= a_trunc_r;
      // shift, restore sign (truncation toward zero)
      c_data_r  <= SAMPLE_W'(b_neg_r ? -quot_s : quot_s);
      c_last_r  <= b_last_r;
      c_trunc_r <= b_trunc_r;
    end
  end

  assign out_ch.valid      = c_valid_r;
  assign out_ch.left_out   = c_data_r;
  assign out_ch.right_out  = c_data_r;
  assign out_ch.last_frame = c_last_r;
  assign out_ch.truncated  = c_trunc_r;

endmodule

// File: design/linear_interp_upsampler_stereo.sv
`timescale 1ns / 1ps
// Linear interpolation upsampler, mono in, stereo out. Each transferred sample
// produces repeat_count frames (clamped to 1..16) stepping linearly from the
// previous sample to the new one; the first sample of an utterance only primes
// the state, and the sample flagged end_of_utterance adds repeat_count more
// frames holding that sample, the last of them flagged last_frame. Once 524288
// frames have left in one utterance, the frame that reached the limit carries
// last_frame (and truncated, unless it was the natural end) and further items
// yield nothing until the utterance ends. The back sequencer issues one frame
// per cycle while the output is not stalled, and takes each job from the queue
// in its idle state before issuing the job's frames; a priming sample is only
// taken. Frames then pass through the issue, product and output registers.
// A two-entry job queue lets the input run ahead of the output. Write
// repeat_count only while the block is idle.
// ---------------------------------------------------------------------------
// linear_interp_upsampler_stereo
// Top level: configuration register, front, job queue and back.
// ---------------------------------------------------------------------------
`include "linear_interp_upsampler_stereo_macros.svh"

module linear_interp_upsampler_stereo import lius_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  lius_in_if.sink          in_ch,
  lius_out_if.source       out_ch
);

  logic [CFG_W-1:0] repeat_count_r, repeat_count_nxt;
  logic             push_valid;
  job_t             push_job;
  logic             queue_full;
  logic             pop;
  q_head_t          head;

  // Repeat count register
  assign repeat_count_nxt = cfg_we ? cfg_wdata : repeat_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      repeat_count_r <= CFG_W'(REPEAT_RESET);
    end else begin
      repeat_count_r <= repeat_count_nxt;
    end
  end

  lius_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .queue_full (queue_full),
    .push_valid (push_valid),
    .push_job   (push_job)
  );

  lius_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_job   (push_job),
    .full       (queue_full),
    .pop        (pop),
    .head       (head)
  );

  lius_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .repeat_count (repeat_count_r),
    .head         (head),
    .pop          (pop),
    .out_ch       (out_ch)
  );

  // Checks
  `LIUS_ASSERT_IMP(a_trunc_is_last, out_ch.valid && out_ch.truncated, out_ch.last_frame)
  `LIUS_ASSERT_IMP(a_stereo_equal, out_ch.valid, out_ch.left_out == out_ch.right_out)
  `LIUS_ASSERT_IMP(a_empty_queue_ready, !head.valid, in_ch.ready)
  `LIUS_ASSERT_NXT(a_push_lands, push_valid && !pop, head.valid)

endmodule
